// ===== design/aik_pkg.sv =====
// Shared types and constants for the arm inverse kinematics block.
`timescale 1ns / 1ps
package aik_pkg;

    // Input item: target point and tool angle
    typedef struct packed {
        logic signed [15:0] target_x;
        logic signed [15:0] target_y;
        logic signed [15:0] target_z;
        logic signed [15:0] tool_angle;
    } t_in;

    // Result item: four joint values
    typedef struct packed {
        logic signed [15:0] base_angle;
        logic signed [15:0] finger_angle;
        logic        [14:0] extension;
        logic signed [15:0] end_angle;
    } t_out;

    // Register indexes
    localparam logic [1:0] REG_PIVOT_HEIGHT = 2'd0;
    localparam logic [1:0] REG_REACH_LIMIT  = 2'd1;
    localparam logic [1:0] REG_EXT_OFFSET   = 2'd2;

    localparam logic [14:0] RST_PIVOT_HEIGHT = 15'd154;
    localparam logic [14:0] RST_REACH_LIMIT  = 15'd2048;
    localparam logic [14:0] RST_EXT_OFFSET   = 15'd819;

    // CORDIC datapath width (Q.8, signed) and magnitude width
    localparam int CW = 28;
    localparam int MW = 26;

    localparam logic [15:0] GAIN_FIX     = 16'd39797;
    localparam logic [15:0] QUARTER_TURN = 16'd16384;
    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
    localparam int          TABLE_LEN    = 24;

    // atan(2^-i) in 2^32 counts per turn
    localparam logic [31:0] ATAN_TAB [0:TABLE_LEN-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

endpackage

// ===== design/arm_inverse_kinematics.sv =====
// Top level: two CORDIC pipelines with gain correction, clamp and offset.
//
//  channel | valid       | ready       | payload
//  input   | i_in_valid  | o_in_ready  | i_in_data  (aik_pkg::t_in)
//  result  | o_out_valid | i_out_ready | o_out_data (aik_pkg::t_out)
//  config  | i_cfg_valid | o_cfg_ready | i_cfg_index, i_cfg_data
//
// One item per cycle while the output register is free or taken; the two CORDIC
// pipelines are each a pre-rotation stage plus one stage per iteration.
// Synchronous active-low reset clears all valid bits and loads register defaults.
// The whole pipeline holds while the output register is full and not taken.
`timescale 1ns / 1ps
module arm_inverse_kinematics #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  aik_pkg::t_in        i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output aik_pkg::t_out       o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [14:0]         i_cfg_data
);

    logic [14:0] r_pivot_height;
    logic [14:0] r_reach_limit;
    logic [14:0] r_ext_offset;
    logic        en;

    // Configuration registers; unknown indexes drop
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pivot_height <= aik_pkg::RST_PIVOT_HEIGHT;
            r_reach_limit  <= aik_pkg::RST_REACH_LIMIT;
            r_ext_offset   <= aik_pkg::RST_EXT_OFFSET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                aik_pkg::REG_PIVOT_HEIGHT: r_pivot_height <= i_cfg_data;
                aik_pkg::REG_REACH_LIMIT:  r_reach_limit  <= i_cfg_data;
                aik_pkg::REG_EXT_OFFSET:   r_ext_offset   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance whenever the output register can take a new item
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // First CORDIC: atan2(y, x) and XY radius
    logic signed [16:0]           zeff;
    logic signed [aik_pkg::CW-1:0] c1_x, c1_y;
    logic                         c1_vld;
    logic [aik_pkg::MW-1:0]       c1_mag;
    logic [31:0]                  c1_ang;
    logic [32:0]                  c1_side;

    assign zeff = {i_in_data.target_z[15], i_in_data.target_z}
                - $signed({2'b00, r_pivot_height});
    assign c1_x = {{(aik_pkg::CW-24){i_in_data.target_x[15]}}, i_in_data.target_x, 8'd0};
    assign c1_y = {{(aik_pkg::CW-24){i_in_data.target_y[15]}}, i_in_data.target_y, 8'd0};

    aik_cordic #(.N(CORDIC_STAGES), .SW(33)) u_cordic_xy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_x     (c1_x),
        .i_y     (c1_y),
        .i_side  ({i_in_data.tool_angle, zeff}),
        .o_valid (c1_vld),
        .o_mag   (c1_mag),
        .o_angle (c1_ang),
        .o_side  (c1_side)
    );

    // Gain stage one: multiply radius, round base angle
    logic [aik_pkg::MW+15:0] r_prod1;
    logic [15:0]             r_a1;
    logic [32:0]             r_side1;
    logic                    r_vld1;
    logic [31:0]             a1_sum;

    assign a1_sum = c1_ang + 32'h0000_8000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else if (en) begin
            r_vld1 <= c1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod1 <= c1_mag * aik_pkg::GAIN_FIX;
            r_a1    <= a1_sum[31:16];
            r_side1 <= c1_side;
        end
    end

    // Second CORDIC: atan2(z_eff, r) and 3D distance
    logic [aik_pkg::MW+15:0]       r20_sum;
    logic signed [aik_pkg::CW-1:0] c2_x, c2_y;
    logic                          c2_vld;
    logic [aik_pkg::MW-1:0]        c2_mag;
    logic [31:0]                   c2_ang;
    logic [31:0]                   c2_side;

    assign r20_sum = r_prod1 + (aik_pkg::MW+16)'(32768);
    assign c2_x    = $signed({2'b00, r20_sum[aik_pkg::MW+15:16]});
    assign c2_y    = {{(aik_pkg::CW-25){r_side1[16]}}, r_side1[16:0], 8'd0};

    aik_cordic #(.N(CORDIC_STAGES), .SW(32)) u_cordic_rz (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_vld1),
        .i_x     (c2_x),
        .i_y     (c2_y),
        .i_side  ({r_side1[32:17], r_a1}),
        .o_valid (c2_vld),
        .o_mag   (c2_mag),
        .o_angle (c2_ang),
        .o_side  (c2_side)
    );

    // Gain stage two: multiply distance, round finger angle
    logic [aik_pkg::MW+15:0] r_prod2;
    logic [15:0]             r_a2;
    logic [31:0]             r_side2;
    logic                    r_vld2;
    logic [31:0]             a2_sum;

    assign a2_sum = c2_ang + 32'h0000_8000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
        end else if (en) begin
            r_vld2 <= c2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod2 <= c2_mag * aik_pkg::GAIN_FIX;
            r_a2    <= a2_sum[31:16];
            r_side2 <= c2_side;
        end
    end

    // Output stage: scale, clamp to reach, subtract offset
    logic [aik_pkg::MW+15:0] dist_sum;
    logic [17:0]             dist_q12;
    logic [14:0]             dist_cl;
    aik_pkg::t_out           n_out;
    aik_pkg::t_out           r_out;
    logic                    r_out_valid;

    assign dist_sum = r_prod2 + (aik_pkg::MW+16)'(32'h0080_0000);
    assign dist_q12 = dist_sum[aik_pkg::MW+15:24];

    always_comb begin
        dist_cl = (dist_q12 > {3'd0, r_reach_limit}) ? r_reach_limit : dist_q12[14:0];
        n_out.base_angle   = r_side2[15:0];
        n_out.finger_angle = r_a2 - aik_pkg::QUARTER_TURN;
        n_out.extension    = (dist_cl > r_ext_offset) ? dist_cl - r_ext_offset : 15'd0;
        n_out.end_angle    = r_side2[31:16];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks
    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid not cleared by reset");

    a_ready_tracks_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not follow output register state");

    a_cfg_reach: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && i_cfg_index == aik_pkg::REG_REACH_LIMIT
        |=> r_reach_limit == $past(i_cfg_data))
        else $error("reach limit write lost");

    a_cfg_pivot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && i_cfg_index == aik_pkg::REG_PIVOT_HEIGHT
        |=> r_pivot_height == $past(i_cfg_data))
        else $error("pivot height write lost");

endmodule

// ===== design/aik_cordic.sv =====
// Pipelined vectoring CORDIC: one pre-rotation stage then one stage per iteration.
`timescale 1ns / 1ps
module aik_cordic #(
    parameter int N  = 16,
    parameter int SW = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic signed [aik_pkg::CW-1:0] i_x,
    input  logic signed [aik_pkg::CW-1:0] i_y,
    input  logic [SW-1:0]              i_side,
    output logic                       o_valid,
    output logic [aik_pkg::MW-1:0]     o_mag,
    output logic [31:0]                o_angle,
    output logic [SW-1:0]              o_side
);

    logic signed [aik_pkg::CW-1:0] r_x    [0:N];
    logic signed [aik_pkg::CW-1:0] r_y    [0:N];
    logic        [31:0]            r_acc  [0:N];
    logic                          r_zero [0:N];
    logic        [SW-1:0]          r_side [0:N];
    logic                          r_vld  [0:N];

    // Pre-rotate: turn left half plane by a half turn, flag the origin
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            r_side[0] <= i_side;
            if (i_x < 0) begin
                r_x[0]   <= -i_x;
                r_y[0]   <= -i_y;
                r_acc[0] <= aik_pkg::HALF_TURN;
            end else begin
                r_x[0]   <= i_x;
                r_y[0]   <= i_y;
                r_acc[0] <= '0;
            end
        end
    end

    // One micro-rotation per stage
    for (genvar s = 0; s < N; s++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[s+1] <= r_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[s+1] <= r_zero[s];
                r_side[s+1] <= r_side[s];
                if (r_y[s] >= 0) begin
                    r_x[s+1]   <= r_x[s] + (r_y[s] >>> s);
                    r_y[s+1]   <= r_y[s] - (r_x[s] >>> s);
                    r_acc[s+1] <= r_acc[s] + aik_pkg::ATAN_TAB[s];
                end else begin
                    r_x[s+1]   <= r_x[s] - (r_y[s] >>> s);
                    r_y[s+1]   <= r_y[s] + (r_x[s] >>> s);
                    r_acc[s+1] <= r_acc[s] - aik_pkg::ATAN_TAB[s];
                end
            end
        end
    end

    // Origin gives zero angle and magnitude; a negative final x also gives zero magnitude
    assign o_valid = r_vld[N];
    assign o_side  = r_side[N];
    assign o_angle = r_zero[N] ? 32'd0 : r_acc[N];
    assign o_mag   = (r_zero[N] || r_x[N] < 0) ? '0 : r_x[N][aik_pkg::MW-1:0];

endmodule

// ===== bench/tb_arm_inverse_kinematics.sv =====
// Testbench for the arm inverse kinematics block: random and directed targets, scoreboard check.
`timescale 1ns / 1ps
module tb_arm_inverse_kinematics;

    localparam int STAGES  = 16;
    localparam int LATENCY = 2 * STAGES + 5;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_ready;
    aik_pkg::t_in  i_in_data;
    logic          o_out_valid;
    logic          i_out_ready;
    aik_pkg::t_out o_out_data;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic [1:0]    i_cfg_index;
    logic [14:0]   i_cfg_data;

    int  mismatches = 0;
    bit  idle_free  = 0;

    arm_inverse_kinematics #(.CORDIC_STAGES(STAGES)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
        mismatches++;
    endtask

    // Joint predictor with its own copy of the registers
    class joint_scoreboard;
        logic [14:0]   pivot_height = aik_pkg::RST_PIVOT_HEIGHT;
        logic [14:0]   reach_limit  = aik_pkg::RST_REACH_LIMIT;
        logic [14:0]   ext_offset   = aik_pkg::RST_EXT_OFFSET;
        aik_pkg::t_out pending[$];

        // Vectoring rotation: angle in 2^32 counts per turn, raw magnitude
        function automatic logic [31:0] vector_angle(input longint px_in,
                input longint py_in, output longint mag);
            longint px, py, dx, dy;
            logic [31:0] acc;
            px = px_in;
            py = py_in;
            acc = '0;
            if (px == 0 && py == 0) begin
                mag = 0;
                return '0;
            end
            if (px < 0) begin
                px = -px;
                py = -py;
                acc = aik_pkg::HALF_TURN;
            end
            for (int i = 0; i < STAGES && i < aik_pkg::TABLE_LEN; i++) begin
                dx = py >>> i;
                dy = px >>> i;
                if (py >= 0) begin
                    px += dx;
                    py -= dy;
                    acc += aik_pkg::ATAN_TAB[i];
                end else begin
                    px -= dx;
                    py += dy;
                    acc -= aik_pkg::ATAN_TAB[i];
                end
            end
            mag = (px < 0) ? 0 : px;
            return acc;
        endfunction

        function automatic logic [15:0] to_turns16(input logic [31:0] acc);
            logic [31:0] s;
            s = acc + 32'h8000;
            return s[31:16];
        endfunction

        function void write_reg(input logic [1:0] idx, input logic [14:0] val);
            case (idx)
                aik_pkg::REG_PIVOT_HEIGHT: pivot_height = val;
                aik_pkg::REG_REACH_LIMIT:  reach_limit  = val;
                aik_pkg::REG_EXT_OFFSET:   ext_offset   = val;
                default: ;
            endcase
        endfunction

        // Note an accepted target and queue its joint values
        function void note_target(input aik_pkg::t_in t);
            longint x, y, zeff, m1, m2, radius, span, ext;
            logic [31:0] a1, a2;
            aik_pkg::t_out o;
            x = t.target_x;
            y = t.target_y;
            zeff = longint'(t.target_z) - longint'(pivot_height);
            a1 = vector_angle(x * 256, y * 256, m1);
            radius = (m1 * aik_pkg::GAIN_FIX + 32768) >>> 16;
            a2 = vector_angle(radius, zeff * 256, m2);
            span = (m2 * aik_pkg::GAIN_FIX + (64'd1 << 23)) >>> 24;
            if (span > reach_limit) span = reach_limit;
            ext = (span > ext_offset) ? span - ext_offset : 0;
            o.base_angle   = to_turns16(a1);
            o.finger_angle = to_turns16(a2) - aik_pkg::QUARTER_TURN;
            o.extension    = ext[14:0];
            o.end_angle    = t.tool_angle;
            pending = {pending, o};
        endfunction

        // Compare a result with the oldest expectation
        task check_joints(input aik_pkg::t_out got);
            aik_pkg::t_out want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected item", 0, 0);
                return;
            end
            want = pending.pop_front();
            if (got.base_angle !== want.base_angle)
                report_mismatch("base_angle", got.base_angle, want.base_angle);
            if (got.finger_angle !== want.finger_angle)
                report_mismatch("finger_angle", got.finger_angle, want.finger_angle);
            if (got.extension !== want.extension)
                report_mismatch("extension", got.extension, want.extension);
            if (got.end_angle !== want.end_angle)
                report_mismatch("end_angle", got.end_angle, want.end_angle);
        endtask
    endclass

    joint_scoreboard board = new();

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // Hold the run to a fixed ceiling
    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic bit idle_now();
        return !idle_free && ($urandom_range(99) < 35);
    endfunction

    // Drain results with random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) board.check_joints(o_out_data);
            i_out_ready <= !idle_now();
        end
    end

    // Offer one item, idling first at random; valid stays high between items unless an idle is drawn
    task automatic send_target(input aik_pkg::t_in t);
        if (idle_now()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while (idle_now()) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= t;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_target(t);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic aik_pkg::t_in mk(input int x, input int y, input int z, input int a);
        aik_pkg::t_in t;
        t.target_x = 16'(x);
        t.target_y = 16'(y);
        t.target_z = 16'(z);
        t.tool_angle = 16'(a);
        return t;
    endfunction

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(3))
            0:       return 16'($urandom);
            1:       return 16'($signed($urandom_range(8192)) - 4096);
            2:       return 16'($signed($urandom_range(64)) - 32);
            default: return $urandom_range(1) ? 16'(16'h7FFF - $urandom_range(3))
                                               : 16'(16'h8000 + $urandom_range(3));
        endcase
    endfunction

    function automatic logic [14:0] rand_reg();
        case ($urandom_range(3))
            0:       return 15'd0;
            1:       return 15'h7FFF;
            2:       return 15'($urandom_range(4096));
            default: return 15'($urandom);
        endcase
    endfunction

    initial begin
        i_rst_n = 0;
        i_in_valid = 0;
        i_in_data = '0;
        i_cfg_valid = 0;
        i_cfg_index = aik_pkg::REG_PIVOT_HEIGHT;
        i_cfg_data = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: origin, axes, negative x, extremes, clamp and floor
        send_target(mk(0, 0, 0, 0));
        send_target(mk(0, 0, 154, 16'h7FFF));
        send_target(mk(-100, 0, 0, 16'h8000));
        send_target(mk(-1, 0, 0, 1));
        send_target(mk(0, 100, 500, -1));
        send_target(mk(0, -100, -500, 12345));
        send_target(mk(32767, 32767, 32767, 0));
        send_target(mk(-32768, -32768, -32768, 0));
        send_target(mk(-32768, 32767, 0, 0));
        send_target(mk(32767, -32768, -32768, 0));
        send_target(mk(100, 100, 100, 0));
        send_target(mk(3000, 0, 0, 0));
        send_target(mk(500, -500, 154, 0));
        drain();

        // Extreme register settings, including an ignored index
        write_reg(aik_pkg::REG_PIVOT_HEIGHT, 15'h7FFF);
        write_reg(aik_pkg::REG_REACH_LIMIT, 15'h7FFF);
        write_reg(aik_pkg::REG_EXT_OFFSET, 15'd0);
        write_reg(2'd3, 15'h1234);
        send_target(mk(32767, 32767, -32768, 0));
        send_target(mk(-32768, 0, 32767, 0));
        send_target(mk(0, 0, 0, 0));
        drain();
        write_reg(aik_pkg::REG_PIVOT_HEIGHT, 15'd0);
        write_reg(aik_pkg::REG_REACH_LIMIT, 15'd0);
        write_reg(aik_pkg::REG_EXT_OFFSET, 15'h7FFF);
        send_target(mk(1000, 1000, 1000, 0));
        send_target(mk(0, 0, 0, 0));
        drain();

        // Random phases with fresh settings; one phase without idling
        for (int phase = 0; phase < 8; phase++) begin
            write_reg(aik_pkg::REG_PIVOT_HEIGHT, rand_reg());
            write_reg(aik_pkg::REG_REACH_LIMIT, rand_reg());
            write_reg(aik_pkg::REG_EXT_OFFSET, rand_reg());
            idle_free = (phase == 3);
            repeat (150) send_target(mk(16'(rand_coord()), 16'(rand_coord()),
                                        16'(rand_coord()), 16'($urandom)));
            drain();
        end
        idle_free = 0;

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// ===== files.f =====
design/aik_pkg.sv
design/aik_cordic.sv
design/arm_inverse_kinematics.sv
bench/tb_arm_inverse_kinematics.sv
